>>> hdl/imadac_pkg.sv
`default_nettype none

package imadac_pkg;

  // Item commands.
  typedef enum logic {
    CMD_DECODE = 1'b0,
    CMD_LOAD   = 1'b1
  } command_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_VOLUME_GAIN  = 1'b0,
    REG_DAC_MIDPOINT = 1'b1
  } cfg_reg_t;

  // Input request: one ADPCM code or a predictor/index load.
  typedef struct packed {
    command_t           command;
    logic [3:0]         code_nibble;
    logic signed [15:0] start_predictor;
    logic [6:0]         start_step_index;
  } in_req_t;

  // Output request: decoded sample and its DAC code.
  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic [11:0]        dac_code;
  } out_req_t;

  // Decoder state carried from one code to the next.
  typedef struct packed {
    logic signed [15:0] predictor;
    logic [6:0]         step_index;
  } dec_state_t;

  localparam int CFG_DATA_W = 12;

  localparam logic [6:0]         STEP_INDEX_MAX  = 7'd88;
  localparam logic signed [15:0] PREDICTOR_RESET = -16'sd131;
  localparam logic [7:0]         VOLUME_RESET    = 8'd1;
  localparam logic [11:0]        MIDPOINT_RESET  = 12'd2048;
  localparam logic [11:0]        DAC_MAX         = 12'd4095;
  localparam logic signed [15:0] PCM_MIN         = -16'sd32768;
  localparam logic signed [15:0] PCM_MAX         = 16'sd32767;

  // Division by 200 is a shift by 3 followed by an exact reciprocal
  // multiply for division by 25, valid for dividends below 2**21.
  localparam int          DIV_PRE_SHIFT = 3;
  localparam int          DIV25_SHIFT   = 26;
  localparam logic [21:0] DIV25_RECIP   = 22'd2684355;

  // Standard IMA step size table.
  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    unique case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Standard IMA index adjustment, selected by the magnitude bits.
  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    unique case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ima_adpcm_dac_decoder_core.sv
`default_nettype none

// IMA ADPCM decoder feeding a 12-bit DAC.
//
// Input channel (in_valid / in_stall / in_data): one request per code. A
// decode request gives one result; a load request sets the predictor and
// step index and gives no result. Output channel (out_valid / out_stall /
// out_data): the clamped 16-bit sample and its 12-bit DAC code.
// A request is taken at a clock edge with valid high and stall low.
// Throughput is one request per cycle while in_stall is low, the predictor
// and step index being updated in the first stage as each request retires.
// A decode result goes from the input register through predictor update and
// gain multiply, reciprocal divide and DAC mapping into the output register.
// When the receiver stalls, the result holds and the pipeline keeps
// filling its empty stages; once all are full, in_stall rises.
// Configuration (cfg_we / cfg_index / cfg_data) writes volume_gain or
// dac_midpoint; the user writes it while the block is idle, not enforced.
// Synchronous reset empties the pipeline and sets predictor -131,
// step index 0, volume_gain 1 and dac_midpoint 2048.
module ima_adpcm_dac_decoder_core (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire imadac_pkg::in_req_t            in_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output imadac_pkg::out_req_t                out_data,
  input  wire                                 cfg_we,
  input  wire imadac_pkg::cfg_reg_t           cfg_index,
  input  wire [imadac_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [7:0]              volume_gain;
  logic [11:0]             dac_midpoint;
  imadac_pkg::dec_state_t  state;
  imadac_pkg::dec_state_t  state_decode;
  imadac_pkg::dec_state_t  state_next;
  imadac_pkg::in_req_t     req;
  logic                    req_valid;
  logic                    req_load;
  logic                    req_retire;
  logic                    take_req;
  logic                    sc_stall;
  logic [6:0]              load_index;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_gain  <= imadac_pkg::VOLUME_RESET;
      dac_midpoint <= imadac_pkg::MIDPOINT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imadac_pkg::REG_VOLUME_GAIN:  volume_gain  <= cfg_data[7:0];
        imadac_pkg::REG_DAC_MIDPOINT: dac_midpoint <= cfg_data[11:0];
      endcase
    end
  end

  // Input register handshake: a load retires at once, a decode waits
  // for the scaling pipeline.
  always_comb begin
    req_load   = (req.command == imadac_pkg::CMD_LOAD);
    req_retire = req_valid && (req_load || !sc_stall);
    take_req   = !req_valid || req_retire;
    in_stall   = !take_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (take_req) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_req) begin
      req <= in_data;
    end
  end

  imadac_predictor u_predictor (
    .cur         (state),
    .code_nibble (req.code_nibble),
    .nxt         (state_decode)
  );

  // Next decoder state for a load or a decode.
  always_comb begin
    if (req.start_step_index > imadac_pkg::STEP_INDEX_MAX) begin
      load_index = imadac_pkg::STEP_INDEX_MAX;
    end else begin
      load_index = req.start_step_index;
    end
    if (req_load) begin
      state_next.predictor  = req.start_predictor;
      state_next.step_index = load_index;
    end else begin
      state_next = state_decode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.predictor  <= imadac_pkg::PREDICTOR_RESET;
      state.step_index <= '0;
    end else if (req_retire) begin
      state <= state_next;
    end
  end

  imadac_scaler u_scaler (
    .clk          (clk),
    .rst          (rst),
    .s_valid      (req_valid && !req_load),
    .s_stall      (sc_stall),
    .s_pcm        (state_decode.predictor),
    .volume_gain  (volume_gain),
    .dac_midpoint (dac_midpoint),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

`ifndef ASSERT_OFF
  // The step index never leaves the table.
  assert property (@(posedge clk) disable iff (rst)
    state.step_index <= imadac_pkg::STEP_INDEX_MAX)
    else $error("step index out of range");

  // A retired load leaves its start predictor in the state.
  assert property (@(posedge clk) disable iff (rst)
    (req_retire && req_load) |=> (state.predictor == $past(req.start_predictor)))
    else $error("load did not set the predictor");

  // A decode waiting on the scaler does not touch the state.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_load && sc_stall) |=> $stable(state))
    else $error("stalled decode changed the state");
`endif

endmodule

`default_nettype wire

>>> hdl/imadac_predictor.sv
`default_nettype none

// One IMA ADPCM decode step: next predictor and step index from one code.
module imadac_predictor (
  input  wire imadac_pkg::dec_state_t cur,
  input  wire logic [3:0]             code_nibble,
  output imadac_pkg::dec_state_t      nxt
);

  logic [14:0]        step;
  logic [15:0]        diff;
  logic signed [17:0] pred_sum;
  logic signed [8:0]  idx_sum;
  logic signed [4:0]  adj;
  logic signed [15:0] pred_next;
  logic [6:0]         idx_next;

  // Difference built from the step and the magnitude bits.
  always_comb begin
    step = imadac_pkg::step_size(cur.step_index);
    diff = 16'(step >> 3);
    if (code_nibble[0]) begin
      diff = diff + 16'(step >> 2);
    end
    if (code_nibble[1]) begin
      diff = diff + 16'(step >> 1);
    end
    if (code_nibble[2]) begin
      diff = diff + 16'(step);
    end
  end

  // Predictor update with clamping to the 16-bit sample range.
  always_comb begin
    if (code_nibble[3]) begin
      pred_sum = {{2{cur.predictor[15]}}, cur.predictor} - {2'b00, diff};
    end else begin
      pred_sum = {{2{cur.predictor[15]}}, cur.predictor} + {2'b00, diff};
    end
    if (pred_sum[17:15] == 3'b000 || pred_sum[17:15] == 3'b111) begin
      pred_next = pred_sum[15:0];
    end else if (pred_sum[17]) begin
      pred_next = imadac_pkg::PCM_MIN;
    end else begin
      pred_next = imadac_pkg::PCM_MAX;
    end
  end

  // Step index update with clamping to the table range.
  always_comb begin
    adj     = imadac_pkg::index_adjust(code_nibble[2:0]);
    idx_sum = $signed({2'b00, cur.step_index}) + $signed({{4{adj[4]}}, adj});
    if (idx_sum[8]) begin
      idx_next = '0;
    end else if (idx_sum[7:0] > {1'b0, imadac_pkg::STEP_INDEX_MAX}) begin
      idx_next = imadac_pkg::STEP_INDEX_MAX;
    end else begin
      idx_next = idx_sum[6:0];
    end
  end

  assign nxt = '{predictor: pred_next, step_index: idx_next};

endmodule

`default_nettype wire

>>> hdl/imadac_scaler.sv
`default_nettype none

// Volume scaling and DAC mapping pipeline: multiply, divide by 200,
// shift, offset and saturate. Two stages plus the output register.
module imadac_scaler (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_valid,
  output logic                        s_stall,
  input  wire logic signed [15:0]     s_pcm,
  input  wire logic [7:0]             volume_gain,
  input  wire logic [11:0]            dac_midpoint,
  output logic                        out_valid,
  input  wire                         out_stall,
  output imadac_pkg::out_req_t        out_data
);

  localparam int MAG_W  = 24;
  localparam int X_W    = MAG_W - imadac_pkg::DIV_PRE_SHIFT;
  localparam int PROD_W = X_W + 22;

  // Stage valids and load enables.
  logic v_mul, v_div;
  logic take_out, take_div, take_mul;

  // Multiply stage.
  logic [15:0]        abs_pcm;
  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   mag_r;
  logic               mul_neg;
  logic signed [15:0] mul_pcm;

  // Divide stage.
  logic [PROD_W-1:0]  div_prod;
  logic [15:0]        quot;
  logic [15:0]        quot_r;
  logic               div_neg;
  logic signed [15:0] div_pcm;

  // Mapping into the output register.
  logic signed [16:0] scaled;
  logic signed [16:0] shifted;
  logic signed [17:0] dac_sum;
  logic [11:0]        dac_sat;

  // Each register loads when empty or when its contents move on.
  always_comb begin
    take_out = !out_valid || !out_stall;
    take_div = !v_div || take_out;
    take_mul = !v_mul || take_div;
    s_stall  = !take_mul;
  end

  // Magnitude of the sample times the gain.
  always_comb begin
    abs_pcm = s_pcm[15] ? 16'(-s_pcm) : 16'(s_pcm);
    mag     = abs_pcm * volume_gain;
  end

  // Division by 200 through the exact reciprocal of 25.
  always_comb begin
    div_prod = {{(PROD_W-X_W){1'b0}}, mag_r[MAG_W-1:imadac_pkg::DIV_PRE_SHIFT]} *
               {{(PROD_W-22){1'b0}}, imadac_pkg::DIV25_RECIP};
    quot     = div_prod[imadac_pkg::DIV25_SHIFT +: 16];
  end

  // Restore the sign (truncation toward zero), floor shift, offset, saturate.
  always_comb begin
    scaled  = div_neg ? -$signed({1'b0, quot_r}) : $signed({1'b0, quot_r});
    shifted = scaled >>> 4;
    dac_sum = $signed({6'b0, dac_midpoint}) + $signed({shifted[16], shifted});
    if (dac_sum[17]) begin
      dac_sat = '0;
    end else if (dac_sum[16:12] != 5'b0) begin
      dac_sat = imadac_pkg::DAC_MAX;
    end else begin
      dac_sat = dac_sum[11:0];
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul     <= 1'b0;
      v_div     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_mul) begin
        v_mul <= s_valid;
      end
      if (take_div) begin
        v_div <= v_mul;
      end
      if (take_out) begin
        out_valid <= v_div;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take_mul) begin
      mag_r   <= mag;
      mul_neg <= s_pcm[15];
      mul_pcm <= s_pcm;
    end
    if (take_div) begin
      quot_r  <= quot;
      div_neg <= mul_neg;
      div_pcm <= mul_pcm;
    end
    if (take_out) begin
      out_data.pcm_sample <= div_pcm;
      out_data.dac_code   <= dac_sat;
    end
  end

`ifndef ASSERT_OFF
  // A full pipeline behind a stalled output pushes back on the input.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && v_mul && v_div) |-> s_stall)
    else $error("scaler accepted a request while full");

  // The output drains when it is taken and nothing follows it.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !v_div) |=> !out_valid)
    else $error("scaler output repeated a request");
`endif

endmodule

`default_nettype wire
